### hdl/uer_pkg.sv
// Package for the ultrasonic echo ranger: register map, reset values,
// phase and status codes, configuration and result words, divide-by-58 helper.
// No dependencies.
package uer_pkg;

  localparam int COUNTER_BITS_DEF = 16;

  localparam int TICK_BITS  = 16;
  localparam int DIST_BITS  = 11;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [15:0] TIMEOUT_RST    = 16'd25000;
  localparam logic [7:0]  TRIG_TICKS_RST = 8'd10;
  localparam logic [7:0]  FAIL_LIMIT_RST = 8'd5;

  // x / 58 for 16-bit x: multiply by ceil(2^22 / 58), keep the top bits
  localparam logic [16:0] DIV58_RECIP = 17'd72316;
  localparam int          DIV58_SHIFT = 22;

  typedef enum logic [1:0] {
    REG_ENABLE     = 2'd0,
    REG_TIMEOUT    = 2'd1,
    REG_TRIG_TICKS = 2'd2,
    REG_FAIL_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_OK        = 2'd1,
    ST_TIMEOUT   = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] echo_timeout_ticks;
    logic [7:0]  trigger_ticks;
    logic [7:0]  fail_limit;
  } cfg_t;

  typedef struct packed {
    logic                  trigger_level;
    logic                  busy_res;
    logic                  done_res;
    status_t               status;
    logic [DIST_BITS-1:0]  dist_cm;
    logic                  healthy;
    logic [COUNT_BITS-1:0] success_count;
    logic [COUNT_BITS-1:0] fail_count;
  } result_t;

  function automatic logic [DIST_BITS-1:0] div58(input logic [TICK_BITS-1:0] x);
    logic [TICK_BITS+17-1:0] prod;
    prod = (TICK_BITS+17)'(x) * (TICK_BITS+17)'(DIV58_RECIP);
    return prod[DIV58_SHIFT +: DIST_BITS];
  endfunction

endpackage

### hdl/uer_apb_regs.sv
// APB register file of the echo ranger: enable, timeout, trigger length, fail limit.
// Flags a write of enable = 0 so the core drops its measurement and tallies.
// Depends on uer_pkg.
module uer_apb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [uer_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [uer_pkg::DATA_BITS-1:0]   pwdata,
  output logic [uer_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  output uer_pkg::cfg_t                   cfg,
  output logic                            abort
);

  logic             wr_en;
  uer_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = uer_pkg::reg_idx_t'(paddr[3:2]);
  assign abort  = wr_en && (idx == uer_pkg::REG_ENABLE) && !pwdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable             <= 1'b0;
      cfg.echo_timeout_ticks <= uer_pkg::TIMEOUT_RST;
      cfg.trigger_ticks      <= uer_pkg::TRIG_TICKS_RST;
      cfg.fail_limit         <= uer_pkg::FAIL_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        uer_pkg::REG_ENABLE:     cfg.enable             <= pwdata[0];
        uer_pkg::REG_TIMEOUT:    cfg.echo_timeout_ticks <= pwdata[15:0];
        uer_pkg::REG_TRIG_TICKS: cfg.trigger_ticks      <= pwdata[7:0];
        uer_pkg::REG_FAIL_LIMIT: cfg.fail_limit         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      uer_pkg::REG_ENABLE:     prdata = {31'd0, cfg.enable};
      uer_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg.echo_timeout_ticks};
      uer_pkg::REG_TRIG_TICKS: prdata = {24'd0, cfg.trigger_ticks};
      uer_pkg::REG_FAIL_LIMIT: prdata = {24'd0, cfg.fail_limit};
      default:                 prdata = '0;
    endcase
  end

endmodule

### hdl/uer_core.sv
// Ranging sequencer of the echo ranger: phase, tick counter and health tallies.
// Advances one tick per step and forms that tick's result word.
// Depends on uer_pkg.
module uer_core #(
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  uer_pkg::cfg_t    cfg,
  input  logic             abort,
  input  logic             step,
  input  logic             start_req,
  input  logic             echo_level,
  output uer_pkg::result_t res
);

  uer_pkg::phase_t                  phase, phase_next;
  logic [uer_pkg::TICK_BITS-1:0]    tick_count, tick_count_next;
  logic [COUNTER_BITS-1:0]          success_tally, success_tally_next;
  logic [COUNTER_BITS-1:0]          fail_tally, fail_tally_next;

  logic [uer_pkg::TICK_BITS-1:0]    wait_base;
  logic                             expired;
  logic                             trig_end;
  logic                             fail_evt;
  logic                             ok_evt;
  logic [31:0]                      succ_wide, fail_wide;

  assign wait_base = (phase == uer_pkg::PH_WAIT && echo_level) ? '0 : tick_count;
  assign expired   = wait_base >= cfg.echo_timeout_ticks;
  assign trig_end  = tick_count >= {8'd0, cfg.trigger_ticks};
  assign fail_evt  = ((phase == uer_pkg::PH_WAIT) ||
                      (phase == uer_pkg::PH_HIGH && echo_level)) && expired;
  assign ok_evt    = (phase == uer_pkg::PH_HIGH) && !echo_level;

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    success_tally_next = success_tally;
    fail_tally_next    = fail_tally;
    if (fail_evt) begin
      phase_next         = uer_pkg::PH_IDLE;
      tick_count_next    = '0;
      success_tally_next = '0;
      if (!(&fail_tally)) fail_tally_next = fail_tally + 1'b1;
    end else if (ok_evt) begin
      phase_next      = uer_pkg::PH_IDLE;
      tick_count_next = '0;
      fail_tally_next = '0;
      if (!(&success_tally)) success_tally_next = success_tally + 1'b1;
    end else begin
      unique case (phase)
        uer_pkg::PH_IDLE: begin
          if (start_req && cfg.enable) begin
            phase_next      = uer_pkg::PH_TRIG;
            tick_count_next = 16'd1;
          end
        end
        uer_pkg::PH_TRIG: begin
          if (trig_end) begin
            phase_next      = uer_pkg::PH_WAIT;
            tick_count_next = '0;
          end else begin
            tick_count_next = tick_count + 1'b1;
          end
        end
        uer_pkg::PH_WAIT: begin
          if (echo_level) phase_next = uer_pkg::PH_HIGH;
          tick_count_next = wait_base + 1'b1;
        end
        uer_pkg::PH_HIGH: tick_count_next = wait_base + 1'b1;
        default: ;
      endcase
    end
  end

  assign succ_wide = 32'(success_tally_next);
  assign fail_wide = 32'(fail_tally_next);

  always_comb begin
    res.trigger_level = (phase_next == uer_pkg::PH_TRIG);
    res.busy_res      = (phase_next != uer_pkg::PH_IDLE);
    res.done_res      = 1'b0;
    res.status        = uer_pkg::ST_NONE;
    res.dist_cm       = '0;
    if (fail_evt) begin
      res.done_res = 1'b1;
      res.status   = uer_pkg::ST_TIMEOUT;
    end else if (ok_evt) begin
      res.done_res = 1'b1;
      res.status   = uer_pkg::ST_OK;
      res.dist_cm  = uer_pkg::div58(tick_count);
    end else if (phase == uer_pkg::PH_IDLE && start_req && !cfg.enable) begin
      res.done_res = 1'b1;
      res.status   = uer_pkg::ST_NOT_READY;
    end
    res.healthy       = cfg.enable && (succ_wide != 32'd0) &&
                        (fail_wide < {24'd0, cfg.fail_limit});
    res.success_count = succ_wide[uer_pkg::COUNT_BITS-1:0];
    res.fail_count    = fail_wide[uer_pkg::COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || abort) begin
      phase         <= uer_pkg::PH_IDLE;
      tick_count    <= '0;
      success_tally <= '0;
      fail_tally    <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      success_tally <= success_tally_next;
      fail_tally    <= fail_tally_next;
    end
  end

endmodule

### hdl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: input word register, sequencer,
// result register and APB configuration registers.
// Depends on uer_pkg, uer_apb_regs, uer_core.
//
// Usage: each input word is one microsecond tick carrying start_req and the
// sampled echo_level; it enters on item_valid with item_stall low. Every word
// yields exactly one result word on res_valid, taken when res_stall is low:
// trigger pin level, busy, done with status and distance in cm, health flag
// and the consecutive success and fail counts.
// A word accepted into the input register is stepped when it advances; its
// result then enters the result register, which raises res_valid and holds
// until the result is taken with res_stall low.
// Throughput: one word per cycle while res_stall is low; the sequencer step
// and divide-by-58 multiply both sit in the single stage between two registers.
// When the receiver stalls, the result register holds and one more word is
// taken into the input register; after that item_stall rises until the
// result is taken.
// Reset: both registers empty, sequencer idle, tallies zero, enable cleared,
// timeout 25000, trigger length 10, fail limit 5. Writing enable = 0 drops a
// running measurement and clears the tallies.
module ultrasonic_echo_ranger #(
  parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [uer_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [uer_pkg::DATA_BITS-1:0]     pwdata,
  output logic [uer_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              start_req,
  input  logic                              echo_level,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic                              trigger_level,
  output logic                              busy_res,
  output logic                              done_res,
  output logic [1:0]                        status,
  output logic [uer_pkg::DIST_BITS-1:0]     dist_cm,
  output logic                              healthy,
  output logic [uer_pkg::COUNT_BITS-1:0]    success_count,
  output logic [uer_pkg::COUNT_BITS-1:0]    fail_count
);

  uer_pkg::cfg_t    cfg;
  logic             abort;
  logic             in_full;
  logic             in_start, in_echo;
  logic             out_full;
  uer_pkg::result_t res_comb, res_q;
  logic             advance;
  logic             accept;

  uer_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .abort   (abort)
  );

  uer_core #(.COUNTER_BITS(COUNTER_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .abort      (abort),
    .step       (advance),
    .start_req  (in_start),
    .echo_level (in_echo),
    .res        (res_comb)
  );

  assign advance    = in_full && (!out_full || !res_stall);
  assign item_stall = in_full && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (accept) in_full <= 1'b1;
      else if (advance) in_full <= 1'b0;
      if (advance) out_full <= 1'b1;
      else if (!res_stall) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_start <= start_req;
      in_echo  <= echo_level;
    end
    if (advance) res_q <= res_comb;
  end

  assign res_valid     = out_full;
  assign trigger_level = res_q.trigger_level;
  assign busy_res      = res_q.busy_res;
  assign done_res      = res_q.done_res;
  assign status        = res_q.status;
  assign dist_cm       = res_q.dist_cm;
  assign healthy       = res_q.healthy;
  assign success_count = res_q.success_count;
  assign fail_count    = res_q.fail_count;

endmodule
